// ===== sv/dq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the double-ended queue: sizes, operation and status codes,
// item structs and the per-cell command type. No dependencies.
package dq_pkg;

  // Store depth and derived widths
  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;
  localparam int CAP_W  = 5;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POP_REAR   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  // What a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LO,
    CELL_FROM_HI,
    CELL_LOAD
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
  } cell_ctrl_t;

endpackage

// ===== sv/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Double-ended queue, up to 16 elements, held as a row of cells with the
// front element in cell 0 and the rear element in cell occupancy-1. Pushes
// at the front shift the row up by one cell, pops at the front shift it down,
// and rear operations write at most one cell. One item is accepted per clock
// cycle while the output register is free or being read; its result appears in
// the output register at the next edge, and a stalled result holds off new items.
// Writing capacity (0 is taken as 1, above 16 as 16) empties the queue;
// there is no clearing pass after reset. Uses dq_pkg and dq_cell.
module double_ended_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  dq_pkg::in_item_t          item,
  output logic                      result_valid,
  input  logic                      result_ready,
  output dq_pkg::out_item_t         result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dq_pkg::CAP_W-1:0]  cfg_data
);

  logic [dq_pkg::CNT_W-1:0]         count;
  logic [dq_pkg::CNT_W-1:0]         count_next;
  logic [dq_pkg::CNT_W-1:0]         capacity;
  logic [dq_pkg::CNT_W-1:0]         capacity_next;
  logic                             accept;
  logic                             cfg_write;
  logic                             is_push;
  logic                             full;
  logic                             empty;
  logic signed [dq_pkg::DATA_W-1:0] rear_value;
  dq_pkg::out_item_t                result_next;
  dq_pkg::cell_ctrl_t               ctrl [dq_pkg::DEPTH];
  logic signed [dq_pkg::DATA_W-1:0] cell_value [dq_pkg::DEPTH];

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign is_push    = (item.mode == dq_pkg::MODE_PUSH_FRONT) ||
                      (item.mode == dq_pkg::MODE_PUSH_REAR);
  assign full       = count >= capacity;
  assign empty      = count == '0;

  // Rear element: the cell just below the fill level
  always_comb begin
    rear_value = '0;
    for (int i = 0; i < dq_pkg::DEPTH; i++) begin
      if (count == dq_pkg::CNT_W'(i + 1)) rear_value = cell_value[i];
    end
  end

  // Cell commands for the accepted item
  always_comb begin
    for (int i = 0; i < dq_pkg::DEPTH; i++) begin
      ctrl[i].cmd = dq_pkg::CELL_HOLD;
      if (accept) begin
        case (item.mode)
          dq_pkg::MODE_PUSH_FRONT: begin
            if (!full) ctrl[i].cmd = (i == 0) ? dq_pkg::CELL_LOAD : dq_pkg::CELL_FROM_LO;
          end
          dq_pkg::MODE_PUSH_REAR: begin
            if (!full && count == dq_pkg::CNT_W'(i)) ctrl[i].cmd = dq_pkg::CELL_LOAD;
          end
          dq_pkg::MODE_POP_FRONT: begin
            if (!empty) ctrl[i].cmd = dq_pkg::CELL_FROM_HI;
          end
          default: ctrl[i].cmd = dq_pkg::CELL_HOLD;
        endcase
      end
    end
  end

  // Row of cells; the ends see the pushed value and their own value
  for (genvar g = 0; g < dq_pkg::DEPTH; g++) begin : g_cell
    dq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .from_lo    ((g == 0) ? item.push_value : cell_value[(g == 0) ? 0 : g - 1]),
      .from_hi    ((g == dq_pkg::DEPTH - 1) ? cell_value[g] :
                   cell_value[(g == dq_pkg::DEPTH - 1) ? g : g + 1]),
      .load_value (item.push_value),
      .value      (cell_value[g])
    );
  end

  // Result and count update for the accepted item
  always_comb begin
    count_next            = count;
    result_next.pop_value = '0;
    result_next.status    = dq_pkg::STATUS_DONE;
    if (is_push) begin
      if (full) result_next.status = dq_pkg::STATUS_FULL;
      else      count_next = count + 1'b1;
    end else if (empty) begin
      result_next.status = dq_pkg::STATUS_EMPTY;
    end else begin
      count_next = count - 1'b1;
      result_next.pop_value = (item.mode == dq_pkg::MODE_POP_FRONT) ? cell_value[0]
                                                                    : rear_value;
    end
    result_next.occupancy = dq_pkg::OCC_W'(count_next);
  end

  // Capacity clamp on a configuration write
  always_comb begin
    if (cfg_data == '0)
      capacity_next = dq_pkg::CNT_W'(1);
    else if (int'(cfg_data) > dq_pkg::DEPTH)
      capacity_next = dq_pkg::CNT_W'(dq_pkg::DEPTH);
    else
      capacity_next = dq_pkg::CNT_W'(cfg_data);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      capacity     <= dq_pkg::CNT_W'(dq_pkg::DEPTH);
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity <= capacity_next;
        count    <= '0;
      end else if (accept) begin
        count <= count_next;
      end
      if (accept)            result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (accept) result <= result_next;
  end

endmodule

// ===== sv/dq_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the deque row: holds one element and can take the
// value of either neighbor or the pushed value. Uses dq_pkg.
module dq_cell (
  input  logic                               clk,
  input  dq_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [dq_pkg::DATA_W-1:0]   from_lo,
  input  logic signed [dq_pkg::DATA_W-1:0]   from_hi,
  input  logic signed [dq_pkg::DATA_W-1:0]   load_value,
  output logic signed [dq_pkg::DATA_W-1:0]   value
);

  // Element register: shift toward either end or load
  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      dq_pkg::CELL_FROM_LO: value <= from_lo;
      dq_pkg::CELL_FROM_HI: value <= from_hi;
      dq_pkg::CELL_LOAD:    value <= load_value;
      default:              value <= value;
    endcase
  end

endmodule

// ===== sv/dq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for double_ended_queue, bound to the top level.
// Uses dq_pkg.
module dq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_ready,
  input logic                      result_valid,
  input logic                      result_ready,
  input dq_pkg::out_item_t         result
);

  // Every accepted item leaves a result in the output register
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> result_valid)
    else $error("accepted item produced no result");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A rejected pop means the queue is empty and returns zero
  a_empty_reject: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == dq_pkg::STATUS_EMPTY |->
      result.occupancy == '0 && result.pop_value == '0)
    else $error("empty rejection with elements held or nonzero value");

  // A rejected push means the queue holds something
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == dq_pkg::STATUS_FULL |-> result.occupancy != '0)
    else $error("full rejection with empty queue");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
